FILE: rtl/core/pairwise_box_collision_macros.svh
// Assertion macros for the pairwise box collision block.
`ifndef PAIRWISE_BOX_COLLISION_MACROS_SVH
`define PAIRWISE_BOX_COLLISION_MACROS_SVH

`ifndef SYNTHESIS
`define PBC_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define PBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBC_ASSERT(lbl, clk, rstn, ante, cons, msg)
`define PBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/core/pbc_pkg.sv
// Shared types and constants for the pairwise box collision block.
`timescale 1ns / 1ps
`default_nettype none
package pbc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned BOUND_W = COORD_W + 2;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned MASK_W  = 64;

  typedef struct packed {
    logic signed [BOUND_W-1:0] lo_x;
    logic signed [BOUND_W-1:0] hi_x;
    logic signed [BOUND_W-1:0] lo_y;
    logic signed [BOUND_W-1:0] hi_y;
    logic signed [BOUND_W-1:0] lo_z;
    logic signed [BOUND_W-1:0] hi_z;
  } box_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [IDX_W-1:0]  idx;
    box_t              box;
    logic [MASK_W-1:0] mask;
  } token_t;

endpackage
`default_nettype wire

FILE: rtl/core/pbc_req_if.sv
// Request channel carrying one entity box.
`timescale 1ns / 1ps
`default_nettype none
interface pbc_req_if;
  import pbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      start_set;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic signed [COORD_W-1:0] size_x;
  logic signed [COORD_W-1:0] size_y;
  logic signed [COORD_W-1:0] size_z;

  modport source (
    output valid, start_set, center_x, center_y, center_z, size_x, size_y, size_z,
    input  ready
  );
  modport sink (
    input  valid, start_set, center_x, center_y, center_z, size_x, size_y, size_z,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/pbc_rsp_if.sv
// Response channel carrying the entity index and its hit mask.
`timescale 1ns / 1ps
`default_nettype none
interface pbc_rsp_if;
  import pbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  entity_index;
  logic [MASK_W-1:0] hit_mask;
  logic              overflow;

  modport source (output valid, entity_index, hit_mask, overflow, input ready);
  modport sink (input valid, entity_index, hit_mask, overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pbc_front.sv
// Entry stage: entity counter and doubled box bounds.
`timescale 1ns / 1ps
`default_nettype none
module pbc_front #(
  parameter int unsigned MAX_ENTITIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              take_i,
  input  logic                              start_set_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] center_y_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] center_z_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] size_x_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] size_y_i,
  input  logic signed [pbc_pkg::COORD_W-1:0] size_z_i,
  output pbc_pkg::token_t                    tok_o
);
  import pbc_pkg::*;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ENTITIES);

  logic [IDX_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] base;
  logic             full;
  token_t           tok_q, tok_d;

  function automatic logic signed [BOUND_W-1:0] abs_ext(logic signed [COORD_W-1:0] s);
    logic signed [BOUND_W-1:0] s_ext;
    s_ext = {{2{s[COORD_W-1]}}, s};
    return s[COORD_W-1] ? -s_ext : s_ext;
  endfunction

  function automatic logic signed [BOUND_W-1:0] dbl(logic signed [COORD_W-1:0] c);
    return {c[COORD_W-1], c, 1'b0};
  endfunction

  always_comb begin
    base  = start_set_i ? '0 : count_q;
    full  = (base >= MAX_IDX);
    count_d = count_q;
    if (take_i && !full) begin
      count_d = base + IDX_W'(1);
    end else if (take_i) begin
      count_d = base;
    end
    tok_d.valid    = take_i;
    tok_d.full     = full;
    tok_d.idx      = base;
    tok_d.mask     = '0;
    tok_d.box.lo_x = dbl(center_x_i) - abs_ext(size_x_i);
    tok_d.box.hi_x = dbl(center_x_i) + abs_ext(size_x_i);
    tok_d.box.lo_y = dbl(center_y_i) - abs_ext(size_y_i);
    tok_d.box.hi_y = dbl(center_y_i) + abs_ext(size_y_i);
    tok_d.box.lo_z = dbl(center_z_i) - abs_ext(size_z_i);
    tok_d.box.hi_z = dbl(center_z_i) + abs_ext(size_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tok_q   <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

FILE: rtl/core/pbc_cell.sv
// One stored box: overlap test against the passing entity and hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pbc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  pbc_pkg::token_t tok_i,
  output pbc_pkg::token_t tok_o
);
  import pbc_pkg::*;

  localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(IDX);

  box_t   box_q;
  token_t tok_q, tok_d;
  logic   hit;

  always_comb begin
    hit = (tok_i.box.lo_x <= box_q.hi_x) && (tok_i.box.hi_x >= box_q.lo_x) &&
          (tok_i.box.lo_y <= box_q.hi_y) && (tok_i.box.hi_y >= box_q.lo_y) &&
          (tok_i.box.lo_z <= box_q.hi_z) && (tok_i.box.hi_z >= box_q.lo_z);
    tok_d = tok_i;
    if (CELL_IDX < tok_i.idx && hit) begin
      tok_d.mask[IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.valid && tok_i.idx == CELL_IDX) begin
      box_q <= tok_i.box;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

FILE: rtl/core/pairwise_box_collision.sv
// Top level of the pairwise box collision block.
// Usage:
//   req_i takes one entity per request: start_set, box center and signed size
//   on three axes in Q16.16. A request with start_set high empties the set first.
//   rsp_o returns one response per request, in order: entity_index within the
//   set, hit_mask with bit j set for each earlier entity j whose box overlaps
//   (touching counts), and overflow when the set was already full.
//   A request passes an entry stage and then all MAX_ENTITIES cells, one per
//   stored box, one cell per cycle unless rsp_o stalls; one request is taken
//   every cycle unless rsp_o stalls.
//   Reset empties the set and the chain; stored boxes are not cleared.
//   When rsp_o stalls, the whole chain holds and req_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_box_collision_macros.svh"
module pairwise_box_collision #(
  parameter int unsigned MAX_ENTITIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pbc_req_if.sink          req_i,
  pbc_rsp_if.source        rsp_o
);
  import pbc_pkg::*;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ENTITIES);

  token_t tok [MAX_ENTITIES+1];
  logic   adv;
  logic   take;

  assign adv         = !tok[MAX_ENTITIES].valid || rsp_o.ready;
  assign req_i.ready = adv;
  assign take        = req_i.valid && adv;

  pbc_front #(
    .MAX_ENTITIES(MAX_ENTITIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .take_i     (take),
    .start_set_i(req_i.start_set),
    .center_x_i (req_i.center_x),
    .center_y_i (req_i.center_y),
    .center_z_i (req_i.center_z),
    .size_x_i   (req_i.size_x),
    .size_y_i   (req_i.size_y),
    .size_z_i   (req_i.size_z),
    .tok_o      (tok[0])
  );

  for (genvar j = 0; j < MAX_ENTITIES; j++) begin : g_cell
    pbc_cell #(
      .IDX(j)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[j]),
      .tok_o (tok[j+1])
    );
  end

  assign rsp_o.valid        = tok[MAX_ENTITIES].valid;
  assign rsp_o.entity_index = tok[MAX_ENTITIES].idx;
  assign rsp_o.hit_mask     = tok[MAX_ENTITIES].mask;
  assign rsp_o.overflow     = tok[MAX_ENTITIES].full;

  `PBC_ASSERT(a_ovf_idx, clk_i, rst_ni, rsp_o.valid, rsp_o.overflow == (rsp_o.entity_index == MAX_IDX), "overflow disagrees with entity index")
  `PBC_ASSERT(a_idx_range, clk_i, rst_ni, rsp_o.valid, rsp_o.entity_index <= MAX_IDX, "entity index beyond capacity")
  `PBC_ASSERT(a_mask_low, clk_i, rst_ni, rsp_o.valid, (rsp_o.hit_mask >> rsp_o.entity_index) == '0, "hit on an entity not earlier in the set")
  `PBC_ASSERT_NEXT(a_new_set, clk_i, rst_ni, take && req_i.start_set, tok[0].valid && tok[0].idx == '0, "new set does not start at index zero")

endmodule
`default_nettype wire
